// ===== src/slot_table_highest_open_tracker_macros.svh =====
// Assertion macros shared by the slot table tracker checkers.
`ifndef SLOT_TABLE_HIGHEST_OPEN_TRACKER_MACROS_SVH
`define SLOT_TABLE_HIGHEST_OPEN_TRACKER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STHO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define STHO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/stho_pkg.sv =====
// Shared types, codes and sizes of the slot table tracker.
package stho_pkg;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int unsigned HI_W       = IDX_W + 1;
  localparam int unsigned ENTRY_W    = 4;

  localparam int unsigned RESET_PREOPEN = 3;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_PREOPEN = '0;

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_INIT  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_CLOSE = 2'd2;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_FILE    = 3'd2;
  localparam logic [2:0] KIND_MAX     = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] slot_index;
    logic [2:0]  slot_kind;
    logic [10:0] need_count;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               slot_is_open;
    logic [2:0]         slot_type;
    logic signed [10:0] highest_open;
    logic [10:0]        free_total;
    logic               enough_free;
  } result_t;

endpackage

// ===== src/stho_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
module stho_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 4
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/stho_engine.sv =====
// Command sequencer: read-modify-write of the slot RAM, downward scan, init sweep.
module stho_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  stho_pkg::item_t   in_item,
  input  logic [10:0]       preopen,
  output logic              res_valid,
  input  logic              res_ready,
  output stho_pkg::result_t res
);
  import stho_pkg::*;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  logic [2:0]             state;
  logic [IDX_W-1:0]       sweep_idx;
  logic [CNT_W-1:0]       init_n;
  logic                   sweep_reply;
  logic [1:0]             cmd_r;
  logic [IDX_W-1:0]       idx_r;
  logic [2:0]             kind_r;
  logic [10:0]            need_r;
  logic                   inr_r;
  logic [IDX_W-1:0]       scan_i;
  logic signed [HI_W-1:0] highest;
  logic [CNT_W-1:0]       free_cnt;
  logic                   slot0_open;
  logic [1:0]             st_r;
  logic                   open_r;
  logic [2:0]             type_r;
  logic                   enough_r;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   rd_open;
  logic [2:0]             rd_type;
  logic                   above;
  logic                   is_highest;
  logic [CNT_W-1:0]       free_upper;
  logic                   enough_now;
  logic [CNT_W-1:0]       sat_n;
  logic                   sweep_open;

  assign rd_open    = rd_data[ENTRY_W-1];
  assign rd_type    = rd_data[2:0];
  assign above      = $signed({1'b0, idx_r}) > highest;
  assign is_highest = $signed({1'b0, idx_r}) == highest;
  assign free_upper = free_cnt - CNT_W'(!slot0_open);
  assign enough_now = (need_r != 11'd0) &&
                      (((int'(TABLE_SIZE) - int'(highest)) > int'(need_r)) ||
                       (32'(free_upper) >= 32'(need_r)));
  assign sat_n      = (32'(preopen) > TABLE_SIZE) ? CNT_W'(TABLE_SIZE) : CNT_W'(preopen);
  assign sweep_open = 32'(sweep_idx) < 32'(init_n);

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = IDX_W'(in_item.slot_index);
      S_LOOK:  rd_addr = idx_r - IDX_W'(1);
      default: rd_addr = scan_i - IDX_W'(1);
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = '0;
    if (state == S_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_idx;
      wr_data = sweep_open ? {1'b1, KIND_FILE} : {1'b0, KIND_UNKNOWN};
    end else if (state == S_LOOK && inr_r) begin
      if (cmd_r == CMD_OPEN) begin
        wr_en   = 1'b1;
        wr_data = {1'b1, kind_r};
      end else if (cmd_r == CMD_CLOSE && !above) begin
        wr_en   = 1'b1;
        wr_data = {1'b0, rd_type};
      end
    end
  end

  stho_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_idx   <= '0;
      init_n      <= CNT_W'(RESET_PREOPEN);
      sweep_reply <= 1'b0;
    end else begin
      case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
          if (sweep_idx == LAST_IDX) begin
            highest    <= HI_W'(int'(init_n) - 1);
            free_cnt   <= CNT_W'(TABLE_SIZE - 32'(init_n));
            slot0_open <= init_n != '0;
            st_r       <= STAT_OK;
            open_r     <= inr_r && (32'(idx_r) < 32'(init_n));
            type_r     <= (inr_r && (32'(idx_r) < 32'(init_n))) ? KIND_FILE : KIND_UNKNOWN;
            enough_r   <= 1'b0;
            state      <= sweep_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_item.cmd;
            idx_r  <= IDX_W'(in_item.slot_index);
            inr_r  <= 32'(in_item.slot_index) < TABLE_SIZE;
            kind_r <= (in_item.slot_kind > KIND_MAX) ? KIND_UNKNOWN : in_item.slot_kind;
            need_r <= in_item.need_count;
            if (in_item.cmd == CMD_INIT) begin
              init_n      <= sat_n;
              sweep_idx   <= '0;
              sweep_reply <= 1'b1;
              state       <= S_SWEEP;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!inr_r) begin
            st_r     <= STAT_RANGE;
            open_r   <= 1'b0;
            type_r   <= KIND_UNKNOWN;
            enough_r <= (cmd_r == CMD_QUERY) && enough_now;
            state    <= S_DONE;
          end else begin
            case (cmd_r)
              CMD_OPEN: begin
                if (!rd_open && free_cnt != '0) begin
                  free_cnt <= free_cnt - CNT_W'(1);
                end
                if (above) begin
                  highest <= $signed({1'b0, idx_r});
                end
                if (idx_r == '0) begin
                  slot0_open <= 1'b1;
                end
                st_r     <= STAT_OK;
                open_r   <= 1'b1;
                type_r   <= kind_r;
                enough_r <= 1'b0;
                state    <= S_DONE;
              end
              CMD_CLOSE: begin
                type_r   <= rd_type;
                enough_r <= 1'b0;
                if (above) begin
                  st_r   <= STAT_CLOSE;
                  open_r <= rd_open;
                  state  <= S_DONE;
                end else begin
                  st_r <= STAT_OK;
                  if (rd_open) begin
                    free_cnt <= free_cnt + CNT_W'(1);
                  end
                  if (idx_r == '0) begin
                    slot0_open <= 1'b0;
                  end
                  open_r <= 1'b0;
                  // walk down from the slot below the closed highest
                  if (is_highest && idx_r != '0) begin
                    scan_i <= idx_r - IDX_W'(1);
                    state  <= S_SCAN;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
              CMD_QUERY: begin
                st_r     <= STAT_OK;
                open_r   <= rd_open;
                type_r   <= rd_type;
                enough_r <= enough_now;
                state    <= S_DONE;
              end
              default: begin
                st_r     <= STAT_OK;
                open_r   <= rd_open;
                type_r   <= rd_type;
                enough_r <= 1'b0;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_open || scan_i == '0) begin
            highest <= $signed({1'b0, scan_i});
            state   <= S_DONE;
          end else begin
            scan_i <= scan_i - IDX_W'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    res.status       = st_r;
    res.slot_is_open = open_r;
    res.slot_type    = type_r;
    res.highest_open = 11'(highest);
    res.free_total   = 11'(free_cnt);
    res.enough_free  = enough_r;
  end

endmodule

// ===== src/slot_table_highest_open_tracker.sv =====
// Top level of the slot table tracker: stream ports, register port, output register.
//
// Keeps a 1024-entry table of slots (open bit and type tag) in one RAM with a
// registered read, plus the highest open index and the closed-slot count in
// registers. Commands arrive one beat per item on the s_ side (cmd in s_tuser)
// and each gives exactly one result beat on the m_ side. An item is worked
// on alone: open, query, out-of-range items and closes that leave the highest
// index in place go from accept to result through a RAM read, an update and a
// hand off. Closing the highest open slot adds a walk down the table, one RAM
// read per slot walked, over up to 1023 slots. Init rewrites every entry
// through the RAM write port. After reset the same sweep runs once with three
// preopened slots, and s_tready stays low until it ends; register writes are
// taken during that time. The result sits in an output register, so a new item
// is accepted while the previous result waits for m_tready. The free-slot
// check of a query needs no walk: the closed count minus slot 0 gives the
// count from slot 1 upward.
module slot_table_highest_open_tracker (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [11:0] slot_index, [14:12] slot_kind, [25:15] need_count, [31:26] zero
  input  logic [31:0]                   s_tdata,
  // [1:0] cmd
  input  logic [1:0]                    s_tuser,
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [2] slot_is_open, [5:3] slot_type, [16:6] highest_open,
  // [27:17] free_total, [28] enough_free, [31:29] zero
  output logic [31:0]                   m_tdata,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stho_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import stho_pkg::*;

  logic [10:0] preopen;
  logic        reg_hit;
  item_t       item;
  result_t     res;
  logic        res_valid;
  logic        res_ready;

  // register file: preopen_count only
  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_PREOPEN;
  assign prdata  = reg_hit ? 32'(preopen) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      preopen <= 11'(RESET_PREOPEN);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      preopen <= pwdata[10:0];
    end
  end

  // unpack the input beat
  always_comb begin
    item.cmd        = s_tuser;
    item.slot_index = s_tdata[11:0];
    item.slot_kind  = s_tdata[14:12];
    item.need_count = s_tdata[25:15];
  end

  stho_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .preopen   (preopen),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, res.enough_free, res.free_total, res.highest_open,
                  res.slot_type, res.slot_is_open, res.status};
    end
  end

endmodule

// ===== src/stho_checker.sv =====
// Port-level checker for the slot table tracker, bound to the top level.
`include "slot_table_highest_open_tracker_macros.svh"

module stho_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [31:0]                   m_tdata
);
  import stho_pkg::*;

  // a stalled result beat holds
  `STHO_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // status carries only defined codes
  `STHO_ASSERT(a_status, m_tvalid |-> m_tdata[1:0] <= STAT_CLOSE, "undefined status code")

  // a close above the highest open index reports the slot as closed
  `STHO_ASSERT(a_close_above, m_tvalid && m_tdata[1:0] == STAT_CLOSE |-> !m_tdata[2], "open slot above highest")

  // out-of-range items report an empty slot
  `STHO_ASSERT(a_range, m_tvalid && m_tdata[1:0] == STAT_RANGE |-> m_tdata[5:2] == 4'd0, "slot fields set on bad index")

  // the table sweep after reset keeps the input closed
  `STHO_ASSERT_ALWAYS(a_reset_sweep, rst |=> !s_tready && !m_tvalid, "beat taken during reset sweep")

endmodule

bind slot_table_highest_open_tracker stho_checker u_stho_checker (.*);
